[rtl/core/assert_macros.svh]
// Assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`endif

[rtl/core/hsp_pkg.sv]
// Package: types and constants of the Hilbert symbol block
`timescale 1ns / 1ps
package hsp_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int PRIME_WIDTH_DEF = 32;

    typedef struct packed {
        logic signed [63:0] value_a;
        logic signed [63:0] value_b;
        logic [31:0]        prime;
    } hsp_in_t;

    typedef struct packed {
        logic is_minus_one;
        logic bad_operand;
    } hsp_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_A,
        ST_DIV_B,
        ST_JAC,
        ST_JDIV,
        ST_DONE
    } hsp_state_t;

endpackage

[rtl/core/hilbert_symbol_at_prime.sv]
// Top level: Hilbert symbol (a,b)_p of two integers at a prime
// One item at a time. Each division by p runs in the shared divider
// (DW is the wider of VALUE_WIDTH and PRIME_WIDTH); an operand with valuation k takes
// k+1 divisions, then for odd p each Jacobi symbol is reduced by halving steps and by
// reduction steps in the divider. Bad operands go straight to the done state. The result
// waits in an output register and s_ready stays low until it is taken.
`timescale 1ns / 1ps
module hilbert_symbol_at_prime #(
    parameter int VALUE_WIDTH = hsp_pkg::VALUE_WIDTH_DEF,
    parameter int PRIME_WIDTH = hsp_pkg::PRIME_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  hsp_pkg::hsp_in_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output hsp_pkg::hsp_out_t m_data
);
    import hsp_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int PW = PRIME_WIDTH;
    localparam int DW = (VW > PW) ? VW : PW;

    hsp_state_t state_reg, state_next;

    logic [VW-1:0] b_reg, b_next;
    logic [PW-1:0] p_reg, p_next;
    logic [DW-1:0] mag_reg, mag_next;
    logic [DW-1:0] x_reg, x_next;
    logic [DW-1:0] n_reg, n_next;
    logic [PW-1:0] rem_a_reg, rem_a_next;
    logic [1:0]    bits_a_reg, bits_a_next;
    logic          neg_a_reg, neg_a_next;
    logic          neg_b_reg, neg_b_next;
    logic          vpar_a_reg, vpar_a_next;
    logic          vpar_b_reg, vpar_b_next;
    logic          flip_reg, flip_next;
    logic          sel_b_reg, sel_b_next;
    logic          ns_a_reg, ns_a_next;
    logic          res_reg, res_next;
    logic          bad_reg, bad_next;

    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [PW-1:0] div_divisor;
    logic          div_done;
    logic [DW-1:0] div_quot;
    logic [PW-1:0] div_rem;

    logic [63:0]   p_wide;
    logic [VW-1:0] a_in, b_in;
    logic [PW-1:0] p_in;
    logic          in_bad;
    logic          div_zero;
    logic [DW-1:0] mag_signed;
    logic [1:0]    bits_cur;
    logic          is_p2, is_peven;
    logic          ns_cur;
    logic [DW-1:0] x_adj_a, x_adj_b;
    logic [DW-1:0] p_ext;

    function automatic logic [VW-1:0] abs_val(input logic [VW-1:0] v);
        return v[VW-1] ? (~v + 1'b1) : v;
    endfunction

    hsp_divider #(.DW(DW), .PW(PW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_comb begin
        p_wide   = {32'd0, s_data.prime};
        a_in     = s_data.value_a[VW-1:0];
        b_in     = s_data.value_b[VW-1:0];
        p_in     = p_wide[PW-1:0];
        in_bad   = (a_in == '0) || (b_in == '0) || (p_in < PW'(2));
        div_zero = (div_rem == '0);
        p_ext    = DW'(p_reg);
        is_p2    = (p_reg == PW'(2));
        is_peven = !p_reg[0];
        ns_cur   = (n_reg == DW'(1)) && flip_reg;
        x_adj_a  = (neg_a_reg && rem_a_reg != '0) ? DW'(p_reg - rem_a_reg) : DW'(rem_a_reg);
        x_adj_b  = (neg_b_reg && div_rem != '0) ? DW'(p_reg - div_rem) : DW'(div_rem);
    end

    always_comb begin
        mag_signed = '0;
        if (state_reg == ST_DIV_A) begin
            mag_signed = neg_a_reg ? (~mag_reg + 1'b1) : mag_reg;
        end else begin
            mag_signed = neg_b_reg ? (~mag_reg + 1'b1) : mag_reg;
        end
        bits_cur = mag_signed[2:1];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = in_bad ? ST_DONE : ST_DIV_A;
                end
            end
            ST_DIV_A: begin
                if (div_done && !div_zero) begin
                    state_next = ST_DIV_B;
                end
            end
            ST_DIV_B: begin
                if (div_done && !div_zero) begin
                    state_next = (is_p2 || is_peven) ? ST_DONE : ST_JAC;
                end
            end
            ST_JAC: begin
                if (x_reg == '0) begin
                    if (sel_b_reg) begin
                        state_next = ST_DONE;
                    end
                end else if (x_reg[0]) begin
                    state_next = ST_JDIV;
                end
            end
            ST_JDIV: begin
                if (div_done) begin
                    state_next = ST_JAC;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        b_next      = b_reg;
        p_next      = p_reg;
        mag_next    = mag_reg;
        x_next      = x_reg;
        n_next      = n_reg;
        rem_a_next  = rem_a_reg;
        bits_a_next = bits_a_reg;
        neg_a_next  = neg_a_reg;
        neg_b_next  = neg_b_reg;
        vpar_a_next = vpar_a_reg;
        vpar_b_next = vpar_b_reg;
        flip_next   = flip_reg;
        sel_b_next  = sel_b_reg;
        ns_a_next   = ns_a_reg;
        res_next    = res_reg;
        bad_next    = bad_reg;
        div_start    = 1'b0;
        div_dividend = mag_reg;
        div_divisor  = p_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    b_next      = b_in;
                    p_next      = p_in;
                    neg_a_next  = a_in[VW-1];
                    neg_b_next  = b_in[VW-1];
                    vpar_a_next = 1'b0;
                    vpar_b_next = 1'b0;
                    mag_next    = DW'(abs_val(a_in));
                    bad_next    = in_bad;
                    res_next    = 1'b0;
                    div_start    = !in_bad;
                    div_dividend = DW'(abs_val(a_in));
                    div_divisor  = p_in;
                end
            end
            ST_DIV_A: begin
                if (div_done) begin
                    div_start = 1'b1;
                    if (div_zero) begin
                        mag_next     = div_quot;
                        vpar_a_next  = !vpar_a_reg;
                        div_dividend = div_quot;
                    end else begin
                        rem_a_next   = div_rem;
                        bits_a_next  = bits_cur;
                        mag_next     = DW'(abs_val(b_reg));
                        div_dividend = DW'(abs_val(b_reg));
                    end
                end
            end
            ST_DIV_B: begin
                if (div_done) begin
                    if (div_zero) begin
                        div_start    = 1'b1;
                        mag_next     = div_quot;
                        vpar_b_next  = !vpar_b_reg;
                        div_dividend = div_quot;
                    end else if (is_p2) begin
                        res_next = (bits_a_reg[0] & bits_cur[0])
                                 ^ (vpar_a_reg & (bits_cur[0] ^ bits_cur[1]))
                                 ^ (vpar_b_reg & (bits_a_reg[0] ^ bits_a_reg[1]));
                    end else if (is_peven) begin
                        res_next = 1'b0;
                    end else begin
                        mag_next   = x_adj_b;
                        x_next     = x_adj_a;
                        n_next     = p_ext;
                        flip_next  = 1'b0;
                        sel_b_next = 1'b0;
                    end
                end
            end
            ST_JAC: begin
                if (x_reg == '0) begin
                    if (!sel_b_reg) begin
                        ns_a_next  = ns_cur;
                        x_next     = mag_reg;
                        n_next     = p_ext;
                        flip_next  = 1'b0;
                        sel_b_next = 1'b1;
                    end else begin
                        res_next = (vpar_b_reg & ns_a_reg) ^ (vpar_a_reg & ns_cur)
                                 ^ (vpar_a_reg & vpar_b_reg & p_reg[0] & p_reg[1]);
                    end
                end else if (!x_reg[0]) begin
                    x_next = x_reg >> 1;
                    if (n_reg[2:0] == 3'd3 || n_reg[2:0] == 3'd5) begin
                        flip_next = !flip_reg;
                    end
                end else begin
                    n_next = x_reg;
                    if (x_reg[1:0] == 2'd3 && n_reg[1:0] == 2'd3) begin
                        flip_next = !flip_reg;
                    end
                    div_start    = 1'b1;
                    div_dividend = n_reg;
                    div_divisor  = x_reg[PW-1:0];
                end
            end
            ST_JDIV: begin
                if (div_done) begin
                    x_next = DW'(div_rem);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        b_reg      <= b_next;
        p_reg      <= p_next;
        mag_reg    <= mag_next;
        x_reg      <= x_next;
        n_reg      <= n_next;
        rem_a_reg  <= rem_a_next;
        bits_a_reg <= bits_a_next;
        neg_a_reg  <= neg_a_next;
        neg_b_reg  <= neg_b_next;
        vpar_a_reg <= vpar_a_next;
        vpar_b_reg <= vpar_b_next;
        flip_reg   <= flip_next;
        sel_b_reg  <= sel_b_next;
        ns_a_reg   <= ns_a_next;
        res_reg    <= res_next;
        bad_reg    <= bad_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready             = (state_reg == ST_IDLE);
    assign m_valid             = (state_reg == ST_DONE);
    assign m_data.is_minus_one = res_reg;
    assign m_data.bad_operand  = bad_reg;

endmodule

[rtl/core/hsp_divider.sv]
// Restoring divider: one quotient bit per cycle
`timescale 1ns / 1ps
module hsp_divider #(
    parameter int DW = 64,
    parameter int PW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [PW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [PW-1:0] remainder
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] q_reg, q_next;
    logic [PW-1:0] r_reg, r_next;
    logic [PW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [PW:0]   shifted;
    logic [PW:0]   diff;
    logic          ge;

    always_comb begin
        shifted = {r_reg, q_reg[DW-1]};
        diff    = shifted - {1'b0, d_reg};
        ge      = shifted >= {1'b0, d_reg};
    end

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next   = {q_reg[DW-2:0], ge};
            r_next   = ge ? diff[PW-1:0] : shifted[PW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

[rtl/core/hsp_checker.sv]
// Port checker for the Hilbert symbol block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hsp_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input hsp_pkg::hsp_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input hsp_pkg::hsp_out_t m_data
);
    import hsp_pkg::*;

    logic s_xfer, m_xfer, s_wait;
    assign s_xfer = s_valid && s_ready;
    assign m_xfer = m_valid && m_ready;
    assign s_wait = s_valid && !s_ready;

    `ASSERT_NEVER(a_bad_is_plus, aclk, aresetn, m_valid && m_data.bad_operand && m_data.is_minus_one)
    `ASSERT_NEVER(a_one_at_a_time, aclk, aresetn, m_valid && s_ready)
    `ASSERT_CLK(a_busy_after_in, aclk, aresetn, s_xfer |=> !s_ready)
    `ASSERT_CLK(a_ready_after_out, aclk, aresetn, m_xfer |=> (s_ready && !m_valid))
    `ASSERT_CLK(a_in_held, aclk, aresetn, s_wait |=> (s_valid && $stable(s_data)))

endmodule

bind hilbert_symbol_at_prime hsp_checker u_hsp_checker (.*);
